>>> hw/rtl/tadv_pkg.sv
// ----------------------------------------------------------------------------
// tadv_pkg
// Shared types and constants for the glyph advance and string box block.
// ----------------------------------------------------------------------------
`default_nettype none

package tadv_pkg;

    // Default sizes of the glyph table and the datapath.
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int METRIC_BITS_DEF = 16;
    localparam int ACC_BITS_DEF    = 32;

    // Item kinds on the input channel.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    // One input beat: a metric load or a character of a string.
    typedef struct packed {
        logic               kind;
        logic        [7:0]  char_code;
        logic signed [15:0] advance_in;
        logic signed [15:0] left_in;
        logic signed [15:0] bottom_in;
        logic signed [15:0] right_in;
        logic signed [15:0] top_in;
        logic               last_char;
    } t_in_beat;

    // One result beat: pen origin, running width and running string box.
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] total_advance;
        logic signed [31:0] box_left;
        logic signed [15:0] box_bottom;
        logic signed [31:0] box_right;
        logic        [14:0] box_top;
        logic               end_of_string;
    } t_out_beat;

endpackage

`default_nettype wire

>>> hw/rtl/text_advance_and_bbox.sv
// An accepted character beat passes the glyph memory read register, then the
// accumulate stage into the output register, before its result beat is presented.
// One beat per cycle unless the output stalls; the pen and box update is combinational.
// Load beats write the glyph memory and produce no result.
// Reset clears the pipeline valid flags, the pen and the string box; the glyph
// memory is not cleared and holds undefined entries until they are loaded.
// ----------------------------------------------------------------------------
// text_advance_and_bbox
// Glyph metric table with running pen position, string width and string box.
// ----------------------------------------------------------------------------
`default_nettype none

module text_advance_and_bbox
    import tadv_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
    parameter int METRIC_BITS = METRIC_BITS_DEF,
    parameter int ACC_BITS    = ACC_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    localparam int IDX_W = $clog2(GLYPH_COUNT);
    localparam int ENT_W = 5 * METRIC_BITS;
    localparam int LW    = (METRIC_BITS > 16) ? METRIC_BITS : 16;
    localparam int SW    = ((ACC_BITS > METRIC_BITS) ? ACC_BITS : METRIC_BITS) + 1;
    localparam int BW    = (METRIC_BITS > 17) ? METRIC_BITS : 17;
    localparam int EW    = (ACC_BITS > 32) ? ACC_BITS : 32;

    localparam logic signed [LW-1:0] MET_HI =
        LW'((LW'(1) << (METRIC_BITS - 1)) - LW'(1));
    localparam logic signed [LW-1:0] MET_LO = -MET_HI - LW'(1);
    localparam logic signed [SW-1:0] ACC_HI =
        SW'((SW'(1) << (ACC_BITS - 1)) - SW'(1));
    localparam logic signed [SW-1:0] ACC_LO = -ACC_HI - SW'(1);
    localparam logic signed [BW-1:0] BOT_MIN = BW'(-32768);
    localparam logic signed [BW-1:0] TOP_MAX = BW'(32767);

    // Table from an 8-bit code to its glyph index, wrapping at the glyph count.
    function automatic logic [256*IDX_W-1:0] build_idx_lut();
        logic [256*IDX_W-1:0] lut;
        int unsigned          m;
        lut = '0;
        m   = 0;
        for (int i = 0; i < 256; i++) begin
            lut[i*IDX_W +: IDX_W] = IDX_W'(m);
            m++;
            if (m == GLYPH_COUNT) begin
                m = 0;
            end
        end
        return lut;
    endfunction

    localparam logic [256*IDX_W-1:0] IDX_LUT = build_idx_lut();

    // Saturate a loaded 16-bit metric to the metric width.
    function automatic logic [METRIC_BITS-1:0] sat_metric(input logic signed [15:0] v);
        logic signed [LW-1:0] t;
        logic signed [LW-1:0] c;
        t = LW'(v);
        if (t > MET_HI) begin
            c = MET_HI;
        end else if (t < MET_LO) begin
            c = MET_LO;
        end else begin
            c = t;
        end
        return c[METRIC_BITS-1:0];
    endfunction

    // Saturate a grown sum to the accumulator width.
    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        if (v > ACC_HI) begin
            c = ACC_HI;
        end else if (v < ACC_LO) begin
            c = ACC_LO;
        end else begin
            c = v;
        end
        return c[ACC_BITS-1:0];
    endfunction

    // Low 32 bits of the sign-extended accumulator value.
    function automatic logic [31:0] to_out32(input logic signed [ACC_BITS-1:0] v);
        logic signed [EW-1:0] t;
        t = EW'(v);
        return t[31:0];
    endfunction

    logic                       in_fire;
    logic                       s1_take;
    logic                       s1_fire;
    logic [IDX_W-1:0]           in_idx;
    logic [ENT_W-1:0]           wr_entry;

    logic [ENT_W-1:0]           r_glyph_mem [GLYPH_COUNT];
    logic [ENT_W-1:0]           r_rd_data;
    logic                       r_s1_valid;
    logic                       r_s1_last;
    logic signed [ACC_BITS-1:0] r_pen;
    logic signed [ACC_BITS-1:0] r_left;
    logic signed [ACC_BITS-1:0] r_right;
    logic signed [15:0]         r_bottom;
    logic        [14:0]         r_top;
    logic                       r_out_valid;
    t_out_beat                  r_out;

    logic signed [METRIC_BITS-1:0] g_adv;
    logic signed [METRIC_BITS-1:0] g_left;
    logic signed [METRIC_BITS-1:0] g_bottom;
    logic signed [METRIC_BITS-1:0] g_right;
    logic signed [METRIC_BITS-1:0] g_top;
    logic signed [ACC_BITS-1:0]    x_left;
    logic signed [ACC_BITS-1:0]    x_right;
    logic signed [BW-1:0]          gb_ext;
    logic signed [BW-1:0]          gt_ext;
    logic signed [BW-1:0]          ab_ext;
    logic signed [BW-1:0]          at_ext;
    logic signed [ACC_BITS-1:0]    n_pen;
    logic signed [ACC_BITS-1:0]    n_left;
    logic signed [ACC_BITS-1:0]    n_right;
    logic signed [15:0]            n_bottom;
    logic        [14:0]            n_top;

    // Handshake: the read stage moves when the output register is free or drains.
    assign s1_take     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || s1_take;
    assign in_fire     = i_in_valid && o_in_ready;
    assign s1_fire     = r_s1_valid && s1_take;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Glyph index and the saturated entry for a load beat.
    assign in_idx   = IDX_LUT[i_in_data.char_code * IDX_W +: IDX_W];
    assign wr_entry = {sat_metric(i_in_data.advance_in), sat_metric(i_in_data.left_in),
                       sat_metric(i_in_data.bottom_in), sat_metric(i_in_data.right_in),
                       sat_metric(i_in_data.top_in)};

    // Glyph memory: load beats write, character beats read. A write and a read
    // never come from the same beat, so the registered read sees every earlier load.
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in_data.kind == KIND_LOAD)) begin
            r_glyph_mem[in_idx] <= wr_entry;
        end
        if (in_fire && (i_in_data.kind == KIND_CHAR)) begin
            r_rd_data <= r_glyph_mem[in_idx];
        end
    end

    // Read stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= in_fire && (i_in_data.kind == KIND_CHAR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_last <= i_in_data.last_char;
        end
    end

    // Accumulate stage: pen advance and box growth from the glyph entry.
    always_comb begin
        g_adv    = r_rd_data[4*METRIC_BITS +: METRIC_BITS];
        g_left   = r_rd_data[3*METRIC_BITS +: METRIC_BITS];
        g_bottom = r_rd_data[2*METRIC_BITS +: METRIC_BITS];
        g_right  = r_rd_data[1*METRIC_BITS +: METRIC_BITS];
        g_top    = r_rd_data[0 +: METRIC_BITS];

        n_pen   = sat_acc(SW'(r_pen) + SW'(g_adv));
        x_left  = sat_acc(SW'(r_pen) + SW'(g_left));
        x_right = sat_acc(SW'(r_pen) + SW'(g_right));
        n_left  = (x_left < r_left) ? x_left : r_left;
        n_right = (x_right > r_right) ? x_right : r_right;

        gb_ext = BW'(g_bottom);
        gt_ext = BW'(g_top);
        ab_ext = BW'(r_bottom);
        at_ext = $signed(BW'(r_top));

        n_bottom = r_bottom;
        if (gb_ext < ab_ext) begin
            n_bottom = (gb_ext < BOT_MIN) ? BOT_MIN[15:0] : gb_ext[15:0];
        end
        n_top = r_top;
        if (gt_ext > at_ext) begin
            n_top = (gt_ext > TOP_MAX) ? TOP_MAX[14:0] : gt_ext[14:0];
        end
    end

    // Pen and box state; a closing character returns them to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen    <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_bottom <= '0;
            r_top    <= '0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                r_pen    <= '0;
                r_left   <= '0;
                r_right  <= '0;
                r_bottom <= '0;
                r_top    <= '0;
            end else begin
                r_pen    <= n_pen;
                r_left   <= n_left;
                r_right  <= n_right;
                r_bottom <= n_bottom;
                r_top    <= n_top;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out.origin_x      <= to_out32(r_pen);
            r_out.total_advance <= to_out32(n_pen);
            r_out.box_left      <= to_out32(n_left);
            r_out.box_bottom    <= n_bottom;
            r_out.box_right     <= to_out32(n_right);
            r_out.box_top       <= n_top;
            r_out.end_of_string <= r_s1_last;
        end
    end

endmodule

`default_nettype wire

>>> bench/text_advance_and_bbox_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_advance_and_bbox_checker
// Watches both channels of the glyph advance block, keeps its own glyph
// table, pen and string box, and compares every result beat with the
// prediction for the oldest character still waiting.
// ----------------------------------------------------------------------------

module text_advance_and_bbox_checker
    import tadv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    localparam int MB = METRIC_BITS_DEF;
    localparam int AB = ACC_BITS_DEF;

    // One stored glyph: advance and box, already limited to the metric width.
    typedef struct packed {
        logic signed [MB-1:0] adv;
        logic signed [MB-1:0] left;
        logic signed [MB-1:0] bottom;
        logic signed [MB-1:0] right;
        logic signed [MB-1:0] top;
    } t_glyph;

    t_glyph               glyph_tab [GLYPH_COUNT_DEF];
    logic signed [AB-1:0] pen_pos    = '0;
    logic signed [AB-1:0] str_left   = '0;
    logic signed [AB-1:0] str_right  = '0;
    logic signed [15:0]   str_bottom = '0;
    logic signed [15:0]   str_top    = '0;

    t_out_beat            string_results_q [$];
    int                   fails   = 0;
    int                   checked = 0;

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint sat_to(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        return clamp_to(v, -hi - 1, hi);
    endfunction

    // A load beat writes one glyph entry.
    task automatic store_glyph(input t_in_beat b);
        int idx;
        idx = b.char_code % GLYPH_COUNT_DEF;
        glyph_tab[idx].adv    = MB'(sat_to(b.advance_in, MB));
        glyph_tab[idx].left   = MB'(sat_to(b.left_in, MB));
        glyph_tab[idx].bottom = MB'(sat_to(b.bottom_in, MB));
        glyph_tab[idx].right  = MB'(sat_to(b.right_in, MB));
        glyph_tab[idx].top    = MB'(sat_to(b.top_in, MB));
    endtask

    // A character beat places its glyph at the pen, grows the box and moves the pen.
    task automatic typeset(input t_in_beat b);
        t_glyph    g;
        longint    origin;
        longint    x;
        t_out_beat r;
        g      = glyph_tab[b.char_code % GLYPH_COUNT_DEF];
        origin = longint'(pen_pos);

        x = sat_to(origin + longint'(g.left), AB);
        if (x < longint'(str_left))
            str_left = AB'(x);
        x = sat_to(origin + longint'(g.right), AB);
        if (x > longint'(str_right))
            str_right = AB'(x);
        if (g.bottom < str_bottom)
            str_bottom = 16'(clamp_to(g.bottom, -32768, 0));
        if (g.top > str_top)
            str_top = 16'(clamp_to(g.top, 0, 32767));
        pen_pos = AB'(sat_to(origin + longint'(g.adv), AB));

        r.origin_x      = origin[31:0];
        r.total_advance = pen_pos[31:0];
        r.box_left      = str_left[31:0];
        r.box_bottom    = str_bottom;
        r.box_right     = str_right[31:0];
        r.box_top       = str_top[14:0];
        r.end_of_string = b.last_char;
        string_results_q.push_back(r);

        // The last character closes the string.
        if (b.last_char) begin
            pen_pos    = '0;
            str_left   = '0;
            str_right  = '0;
            str_bottom = '0;
            str_top    = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    task automatic compare_beat(input t_out_beat got);
        t_out_beat want;
        if (string_results_q.size() == 0) begin
            $error("Result beat arrived with no character waiting for it");
            fails++;
        end else begin
            want = string_results_q.pop_front();
            check_field("origin_x", want.origin_x, got.origin_x);
            check_field("total_advance", want.total_advance, got.total_advance);
            check_field("box_left", want.box_left, got.box_left);
            check_field("box_bottom", 32'(want.box_bottom), 32'(got.box_bottom));
            check_field("box_right", want.box_right, got.box_right);
            check_field("box_top", 32'(want.box_top), 32'(got.box_top));
            check_field("end_of_string", 32'(want.end_of_string),
                        32'(got.end_of_string));
            checked++;
        end
    endtask

    // A result is registered after its character is accepted, so compare before predicting.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready)
                compare_beat(i_out_data);
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.kind == KIND_LOAD)
                    store_glyph(i_in_data);
                else
                    typeset(i_in_data);
            end
        end
        o_fail_count <= fails;
        o_pending    <= string_results_q.size();
        o_checked    <= checked;
    end

endmodule

>>> bench/tb_text_advance_and_bbox.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_advance_and_bbox
// Drives metric loads and strings of characters into the glyph advance block
// with random gaps and stalls, including one long output hold-off and glyphs
// with extreme and inverted boxes. The checker beside the block predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_text_advance_and_bbox;
    import tadv_pkg::*;

    localparam int TOTAL_ITEMS = 1450;
    localparam int HOLD_AT     = 300;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN       = 16;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_beat out_data;

    int        fail_count;
    int        pending;
    int        checked;

    int        send_calm = 0;
    int        n_beats   = 0;
    int        n_loads   = 0;
    int        n_chars   = 0;
    int        n_strings = 0;
    bit        loaded [256];
    logic [7:0] loaded_codes [$];

    text_advance_and_bbox dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    text_advance_and_bbox_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Offer one beat after a random gap and hold it until accepted.
    task automatic send_beat(input t_in_beat b);
        int gap;
        if (send_calm > 0) begin
            send_calm--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 15) == 0)
                send_calm = $urandom_range(8, 40);
            gap = $urandom_range(0, 13);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        n_beats++;
        if (b.kind == KIND_LOAD) begin
            n_loads++;
        end else begin
            n_chars++;
            if (b.last_char)
                n_strings++;
        end
    endtask

    task automatic load_glyph(input logic [7:0] code, input logic signed [15:0] adv,
                              input logic signed [15:0] left, input logic signed [15:0] bottom,
                              input logic signed [15:0] right, input logic signed [15:0] top,
                              input logic last);
        t_in_beat b;
        b.kind       = KIND_LOAD;
        b.char_code  = code;
        b.advance_in = adv;
        b.left_in    = left;
        b.bottom_in  = bottom;
        b.right_in   = right;
        b.top_in     = top;
        b.last_char  = last;
        send_beat(b);
        if (!loaded[code]) begin
            loaded[code] = 1'b1;
            loaded_codes.push_back(code);
        end
    endtask

    // Metric fields of a character beat are unused and carry noise.
    task automatic type_char(input logic [7:0] code, input logic last);
        t_in_beat b;
        b            = t_in_beat'({$urandom, $urandom, $urandom});
        b.kind       = KIND_CHAR;
        b.char_code  = code;
        b.last_char  = last;
        send_beat(b);
    endtask

    function automatic logic signed [15:0] rand_metric();
        case ($urandom_range(0, 15))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_random_glyph();
        load_glyph(8'($urandom_range(0, 255)), rand_metric(), rand_metric(), rand_metric(),
                   rand_metric(), rand_metric(), 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [7:0] pick_loaded();
        return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
    endfunction

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial begin
        int stall;
        int calm;
        int n_taken;
        bit held;
        calm    = 0;
        n_taken = 0;
        held    = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (calm > 0) begin
                calm--;
                stall = 0;
            end else begin
                if ($urandom_range(0, 15) == 0)
                    calm = $urandom_range(8, 40);
                stall = $urandom_range(0, 13);
            end
            if (!held && n_taken == HOLD_AT) begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            n_taken++;
        end
    end

    // Stimulus and verdict.
    initial begin
        int k;
        int len;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme and inverted boxes, single-character strings,
        // a reload in the middle of a string, and a load that carries last.
        load_glyph(8'h00, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1);
        load_glyph(8'hFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0);
        load_glyph(8'h01, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        load_glyph(8'h80, 16'sd600, -16'sd50, -16'sd200, 16'sd550, 16'sd700, 1'b0);
        type_char(8'h01, 1'b1);
        type_char(8'hFF, 1'b0);
        type_char(8'h00, 1'b0);
        type_char(8'h80, 1'b0);
        type_char(8'hFF, 1'b1);
        type_char(8'h00, 1'b1);
        type_char(8'h80, 1'b0);
        load_glyph(8'h80, 16'sd250, 16'sd10, -16'sd20, 16'sd240, 16'sd480, 1'b1);
        type_char(8'h80, 1'b1);
        type_char(8'h80, 1'b0);
        type_char(8'h80, 1'b0);
        type_char(8'h01, 1'b1);

        // Random: mostly well-formed strings over loaded glyphs, some loads between.
        while (n_beats < TOTAL_ITEMS) begin
            if ($urandom_range(0, 99) < 20) begin
                load_random_glyph();
            end else begin
                case ($urandom_range(0, 19))
                    0:             len = 1;
                    1, 2, 3, 4, 5: len = $urandom_range(13, 40);
                    default:       len = $urandom_range(1, 12);
                endcase
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        load_random_glyph();
                    type_char(pick_loaded(), k == len - 1);
                end
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN) @(posedge clk);

        $display("Covered %0d metric loads and %0d characters in %0d strings,", n_loads,
                 n_chars, n_strings);
        $display("with random gaps, stalls and one long hold-off; %0d results compared.",
                 checked);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tadv_pkg.sv
hw/rtl/text_advance_and_bbox.sv
bench/text_advance_and_bbox_checker.sv
bench/tb_text_advance_and_bbox.sv
